/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// The checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/sbcd_pkg.sv */
// ----------------------------------------------------------------------------
// sbcd_pkg
// Shared constants and the record that travels down the digit chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbcd_pkg;

  localparam int DIGITS  = 16;
  localparam int DIG_W   = DIGITS * 4;
  localparam int FIELD_W = 64;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUB = 1'b1;

  // One request in flight. x and y shift right by a digit per cell, and the
  // result digits enter r from the top.
  typedef struct packed {
    logic [DIG_W-1:0] x;
    logic [DIG_W-1:0] y;
    logic [DIG_W-1:0] r;
    logic             carry;
    logic             add;
    logic             neg;
    logic             gt;
    logic             eq;
    logic             bad;
  } work_t;

endpackage

`default_nettype wire

/* rtl/sbcd_in_if.sv */
// ----------------------------------------------------------------------------
// sbcd_in_if
// Request channel: command and two signed BCD operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbcd_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] a_digits;
  logic        a_neg;
  logic [63:0] b_digits;
  logic        b_neg;

  modport source (output valid, command, a_digits, a_neg, b_digits, b_neg,
                  input ready);
  modport sink (input valid, command, a_digits, a_neg, b_digits, b_neg,
                output ready);
endinterface

`default_nettype wire

/* rtl/sbcd_out_if.sv */
// ----------------------------------------------------------------------------
// sbcd_out_if
// Result channel: signed BCD result and comparison flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbcd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_digits;
  logic        result_neg;
  logic        overflow;
  logic        a_greater;
  logic        a_equal;
  logic        bad_digit;

  modport source (output valid, result_digits, result_neg, overflow, a_greater,
                  a_equal, bad_digit, input ready);
  modport sink (input valid, result_digits, result_neg, overflow, a_greater,
                a_equal, bad_digit, output ready);
endinterface

`default_nettype wire

/* rtl/sbcd_front.sv */
// ----------------------------------------------------------------------------
// sbcd_front
// Entry stage: sign handling, comparison, path choice and digit check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbcd_front
  import sbcd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sbcd_in_if.sink   op,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output work_t     dn_data
);

  logic [DIG_W-1:0] a;
  logic [DIG_W-1:0] b;
  logic             an;
  logic             bn;
  logic             beff;
  logic             a_gt_b;
  logic             a_eq_b;
  logic             bad;
  logic             take;
  work_t            work_next;

  assign op.ready = !dn_valid || dn_ready;
  assign take     = op.valid && op.ready;

  always_comb begin
    a      = op.a_digits[DIG_W-1:0];
    b      = op.b_digits[DIG_W-1:0];
    an     = op.a_neg && (a != '0);
    bn     = op.b_neg && (b != '0);
    a_gt_b = a > b;
    a_eq_b = a == b;
    bad    = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (a[4*i +: 4] > DIGIT_MAX || b[4*i +: 4] > DIGIT_MAX) begin
        bad = 1'b1;
      end
    end
    beff = ((op.command == CMD_SUB) ? !bn : bn) && (b != '0);

    work_next.r     = '0;
    work_next.carry = 1'b0;
    work_next.bad   = bad;
    work_next.eq    = (an == bn) && a_eq_b;
    if (an != bn) begin
      work_next.gt = !an;
    end else if (!an) begin
      work_next.gt = a_gt_b;
    end else begin
      work_next.gt = !a_gt_b && !a_eq_b;
    end

    // Differing signs subtract the smaller magnitude from the larger one.
    work_next.add = (an == beff);
    if (work_next.add || a_gt_b || a_eq_b) begin
      work_next.x   = a;
      work_next.y   = b;
      work_next.neg = an;
    end else begin
      work_next.x   = b;
      work_next.y   = a;
      work_next.neg = beff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (op.ready) begin
      dn_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dn_data <= work_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/sbcd_cell.sv */
// ----------------------------------------------------------------------------
// sbcd_cell
// One decimal digit step: adds or subtracts the low digit pair with carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbcd_cell
  import sbcd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire work_t up_data,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output work_t      dn_data
);

  logic [3:0] xd;
  logic [3:0] yd;
  logic [4:0] sum5;
  logic [4:0] diff5;
  logic [4:0] fix5;
  logic [3:0] d;
  logic       c;
  work_t      work_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    xd    = up_data.x[3:0];
    yd    = up_data.y[3:0];
    sum5  = {1'b0, xd} + {1'b0, yd} + {4'b0, up_data.carry};
    diff5 = {1'b0, xd} - {1'b0, yd} - {4'b0, up_data.carry};
    fix5  = '0;
    if (up_data.add) begin
      if (sum5 > {1'b0, DIGIT_MAX}) begin
        fix5 = sum5 - RADIX;
        c    = 1'b1;
      end else begin
        fix5 = sum5;
        c    = 1'b0;
      end
    end else begin
      // A negative difference wraps; adding ten restores the digit.
      if (diff5[4]) begin
        fix5 = diff5 + RADIX;
        c    = 1'b1;
      end else begin
        fix5 = diff5;
        c    = 1'b0;
      end
    end
    d = fix5[3:0];

    work_next       = up_data;
    work_next.x     = {4'b0, up_data.x[DIG_W-1:4]};
    work_next.y     = {4'b0, up_data.y[DIG_W-1:4]};
    work_next.r     = {d, up_data.r[DIG_W-1:4]};
    work_next.carry = c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= work_next;
    end
  end

  `ASSERT_NEXT(a_cell_hold, clk, rst, dn_valid && !dn_ready,
               dn_valid && $stable(dn_data))
  `ASSERT_NEXT(a_cell_load, clk, rst, up_valid && up_ready, dn_valid)
  `ASSERT_IMPLIES(a_cell_ready, clk, rst, !dn_valid, up_ready)

endmodule

`default_nettype wire

/* rtl/signed_bcd_add_subtract_unit.sv */
// ----------------------------------------------------------------------------
// signed_bcd_add_subtract_unit
// Signed-magnitude packed BCD adder and subtractor with compare flags.
// ----------------------------------------------------------------------------
// Requests arrive on op (valid/ready): a command (add or subtract), two packed
// BCD magnitudes with sign bits. Results leave on res (valid/ready): the signed
// BCD result, the top-digit carry of a magnitude sum, signed greater and equal
// flags for a against b, and a flag for any nibble above nine.
// A request passes an entry stage, one digit cell per decimal digit (sixteen)
// and an output register; the entry stage loads at the edge that takes the
// request. One request is taken per cycle while nothing stalls; the digit
// cells form a pipeline and each holds one request.
// Every stage has its own valid bit, so empty stages fill while the receiver
// stalls, and requests keep being taken until the chain is full. A held
// result stays stable on res until taken.
// Reset clears every valid bit; no request is lost or repeated after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module signed_bcd_add_subtract_unit
  import sbcd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sbcd_in_if.sink    op,
  sbcd_out_if.source res
);

  logic        chain_valid [DIGITS+1];
  logic        chain_ready [DIGITS+1];
  work_t       chain_data  [DIGITS+1];

  logic               last_ready;
  work_t              last;
  logic [FIELD_W-1:0] digits_next;
  logic               zero;

  sbcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    sbcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  assign last_ready         = !res.valid || res.ready;
  assign chain_ready[DIGITS] = last_ready;
  assign last               = chain_data[DIGITS];

  always_comb begin
    digits_next             = '0;
    digits_next[DIG_W-1:0]  = last.r;
    zero                    = (last.r == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (last_ready) begin
      res.valid <= chain_valid[DIGITS];
    end
  end

  // A bad digit clears every other field; a zero result is never negative.
  always_ff @(posedge clk) begin
    if (chain_valid[DIGITS] && last_ready) begin
      res.result_digits <= last.bad ? '0 : digits_next;
      res.result_neg    <= !last.bad && last.neg && !zero;
      res.overflow      <= !last.bad && last.add && last.carry;
      res.a_greater     <= !last.bad && last.gt;
      res.a_equal       <= !last.bad && last.eq;
      res.bad_digit     <= last.bad;
    end
  end

  `ASSERT_IMPLIES(a_neg_nonzero, clk, rst, res.valid && res.result_neg,
                  res.result_digits != '0)
  `ASSERT_IMPLIES(a_bad_clears, clk, rst, res.valid && res.bad_digit,
                  !res.result_neg && !res.overflow && !res.a_greater &&
                  !res.a_equal && res.result_digits == '0)
  `ASSERT_IMPLIES(a_cmp_excl, clk, rst, res.valid,
                  !(res.a_greater && res.a_equal))

endmodule

`default_nettype wire

/* tb/sbcd_result_checker.sv */
// ----------------------------------------------------------------------------
// sbcd_result_checker
// Watches both channels of the signed BCD unit and checks every result.
// ----------------------------------------------------------------------------
// Each accepted request is turned into the answer it must produce. Answers wait
// in order until the matching result is accepted, which is then compared field
// by field. Mismatches and results that nobody asked for bump the fail count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcd_result_checker
  import sbcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sbcd_in_if   op,
  sbcd_out_if  res,
  output int   fails,
  output int   pending
);

  typedef struct packed {
    logic [63:0] digits;
    logic        neg;
    logic        ovf;
    logic        gt;
    logic        eq;
    logic        bad;
  } answer_t;

  answer_t answers_q[$];

  function automatic answer_t compute_signed_bcd(input logic cmd, input logic [63:0] a_raw,
                                                 input logic a_sign, input logic [63:0] b_raw,
                                                 input logic b_sign);
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] big;
    logic [63:0] little;
    logic [63:0] r;
    logic        an;
    logic        bn;
    logic        b_eff;
    int          carry;
    int          d;
    answer_t     ans;
    mask = '0;
    for (int i = 0; i < DIGITS && i < 16; i++) mask[4*i +: 4] = 4'hF;
    a = a_raw & mask;
    b = b_raw & mask;
    ans = '0;
    for (int i = 0; i < DIGITS && i < 16; i++) begin
      if (a[4*i +: 4] > DIGIT_MAX || b[4*i +: 4] > DIGIT_MAX) ans.bad = 1'b1;
    end
    if (ans.bad) return ans;

    // A zero magnitude is positive whatever its sign bit says.
    an = a_sign && (a != 0);
    bn = b_sign && (b != 0);
    ans.eq = (an == bn) && (a == b);
    if (an != bn) ans.gt = !an;
    else if (!an) ans.gt = a > b;
    else ans.gt = a < b;

    // Subtraction is addition with the sign of b flipped.
    b_eff = ((cmd == CMD_SUB) ? !bn : bn) && (b != 0);
    r = '0;
    carry = 0;
    if (an == b_eff) begin
      for (int i = 0; i < DIGITS && i < 16; i++) begin
        d = int'(a[4*i +: 4]) + int'(b[4*i +: 4]) + carry;
        if (d > int'(DIGIT_MAX)) begin
          d -= int'(RADIX);
          carry = 1;
        end else begin
          carry = 0;
        end
        r[4*i +: 4] = d[3:0];
      end
      ans.ovf = (carry != 0);
      ans.neg = an;
    end else begin
      if (a >= b) begin
        big = a;
        little = b;
        ans.neg = an;
      end else begin
        big = b;
        little = a;
        ans.neg = b_eff;
      end
      for (int i = 0; i < DIGITS && i < 16; i++) begin
        d = int'(big[4*i +: 4]) - int'(little[4*i +: 4]) - carry;
        if (d < 0) begin
          d += int'(RADIX);
          carry = 1;
        end else begin
          carry = 0;
        end
        r[4*i +: 4] = d[3:0];
      end
    end
    r &= mask;
    if (r == 0) ans.neg = 1'b0;
    ans.digits = r;
    return ans;
  endfunction

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (op.valid && op.ready) begin
        answers_q = {answers_q, compute_signed_bcd(op.command, op.a_digits, op.a_neg,
                                                   op.b_digits, op.b_neg)};
      end
      if (res.valid && res.ready) begin
        if (answers_q.size() == 0) begin
          fails++;
          $display("%0t ns: result with no request waiting, actual %h", $time,
                   res.result_digits);
        end else begin
          want = answers_q.pop_front();
          check_field("result_digits", want.digits, res.result_digits);
          check_field("result_neg", 64'(want.neg), 64'(res.result_neg));
          check_field("overflow", 64'(want.ovf), 64'(res.overflow));
          check_field("a_greater", 64'(want.gt), 64'(res.a_greater));
          check_field("a_equal", 64'(want.eq), 64'(res.a_equal));
          check_field("bad_digit", 64'(want.bad), 64'(res.bad_digit));
        end
      end
      pending <= answers_q.size();
    end
  end

endmodule

/* tb/signed_bcd_add_subtract_unit_test.sv */
// ----------------------------------------------------------------------------
// signed_bcd_add_subtract_unit_test
// Stimulus and verdict for the signed BCD add/subtract unit.
// ----------------------------------------------------------------------------
// A directed set covers the sign, zero, wrap and bad-digit corners, then
// random requests follow with random idling on both channels, one long
// receiver stall, a quiet stretch, and drains. The checker does the compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_bcd_add_subtract_unit_test;
  import sbcd_pkg::*;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int STALL_AT        = 300;
  localparam int STALL_CYCLES    = 80;
  localparam int QUIET_FROM      = 600;
  localparam int QUIET_TO        = 800;
  localparam int DRAIN_AT        = 1000;
  localparam int HANG_LIMIT      = 1000;
  localparam logic [63:0] ALL_NINES = 64'h9999_9999_9999_9999;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   pending;
  int   sent_count = 0;
  bit   quiet = 1'b0;

  sbcd_in_if  op_bus ();
  sbcd_out_if res_bus ();

  signed_bcd_add_subtract_unit DUT (
    .clk(clk),
    .rst(rst),
    .op (op_bus),
    .res(res_bus)
  );

  sbcd_result_checker u_checker (
    .clk    (clk),
    .rst    (rst),
    .op     (op_bus),
    .res    (res_bus),
    .fails  (fails),
    .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand_bcd(input int unsigned len);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < len && i < DIGITS; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  function automatic logic [63:0] spoil_digit(input logic [63:0] v);
    int unsigned pos;
    pos = $urandom_range(0, DIGITS - 1);
    v[4*pos +: 4] = 4'($urandom_range(10, 15));
    return v;
  endfunction

  function automatic int unsigned rand_length();
    // Mostly short numbers so that equal and near-equal operands come up often.
    if ($urandom_range(0, 99) < 70) return $urandom_range(1, 4);
    return $urandom_range(1, DIGITS);
  endfunction

  task automatic send_request(input logic cmd, input logic [63:0] a, input logic a_sign,
                              input logic [63:0] b, input logic b_sign);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      op_bus.valid <= 1'b0;
      @(posedge clk);
    end
    op_bus.valid    <= 1'b1;
    op_bus.command  <= cmd;
    op_bus.a_digits <= a;
    op_bus.a_neg    <= a_sign;
    op_bus.b_digits <= b;
    op_bus.b_neg    <= b_sign;
    do @(posedge clk); while (!op_bus.ready);
    sent_count++;
  endtask

  task automatic wait_drained();
    op_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls, none in the quiet stretch, and one long hold-off
  // while the sender keeps offering requests.
  initial begin
    bit stalled;
    stalled = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      if (!stalled && sent_count >= STALL_AT) begin
        stalled = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        res_bus.ready <= quiet || ($urandom_range(0, 99) >= 7);
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] a;
    logic [63:0] b;
    op_bus.valid    = 1'b0;
    op_bus.command  = CMD_ADD;
    op_bus.a_digits = '0;
    op_bus.a_neg    = 1'b0;
    op_bus.b_digits = '0;
    op_bus.b_neg    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zeros, negative zeros and wrapped sums that end up at zero.
    send_request(CMD_ADD, 64'h0, 1'b0, 64'h0, 1'b0);
    send_request(CMD_ADD, 64'h0, 1'b1, 64'h0, 1'b1);
    send_request(CMD_SUB, 64'h0, 1'b0, 64'h0, 1'b1);
    send_request(CMD_ADD, 64'h1, 1'b0, 64'h0, 1'b1);
    send_request(CMD_ADD, ALL_NINES, 1'b0, 64'h1, 1'b0);
    send_request(CMD_ADD, ALL_NINES, 1'b1, 64'h1, 1'b1);
    send_request(CMD_ADD, ALL_NINES, 1'b1, 64'h2, 1'b1);
    send_request(CMD_SUB, ALL_NINES, 1'b0, ALL_NINES, 1'b1);
    send_request(CMD_ADD, 64'h5000_0000_0000_0000, 1'b0, 64'h5000_0000_0000_0000, 1'b0);
    // Difference path with each sign order, and equal magnitudes.
    send_request(CMD_SUB, 64'h5, 1'b0, 64'h5, 1'b0);
    send_request(CMD_SUB, 64'h3, 1'b0, 64'h7, 1'b0);
    send_request(CMD_SUB, 64'h3, 1'b1, 64'h7, 1'b1);
    send_request(CMD_SUB, 64'h7, 1'b1, 64'h3, 1'b1);
    send_request(CMD_ADD, 64'h123, 1'b0, 64'h456, 1'b1);
    send_request(CMD_SUB, 64'h1000_0000_0000_0000, 1'b0, 64'h1, 1'b0);
    send_request(CMD_ADD, 64'h5, 1'b1, 64'h3, 1'b0);
    send_request(CMD_SUB, 64'h3, 1'b1, 64'h5, 1'b1);
    send_request(CMD_SUB, ALL_NINES, 1'b1, ALL_NINES, 1'b1);
    // Nibbles above nine, low and high, in either operand.
    send_request(CMD_ADD, 64'hA, 1'b0, 64'h1, 1'b0);
    send_request(CMD_SUB, 64'h1, 1'b1, 64'hF000_0000_0000_0000, 1'b0);
    send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(CMD_SUB, 64'h8888_8888_8888_8888, 1'b0, 64'h0000_00C0_0000_0000, 1'b1);
    wait_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet = (n >= QUIET_FROM) && (n < QUIET_TO);
      if (n == DRAIN_AT) wait_drained();
      a = ($urandom_range(0, 99) < 4) ? ALL_NINES : rand_bcd(rand_length());
      case ($urandom_range(0, 19))
        0, 1:    b = a;
        2:       b = '0;
        3:       b = ALL_NINES;
        default: b = rand_bcd(rand_length());
      endcase
      if ($urandom_range(0, 99) < 3) a = spoil_digit(a);
      if ($urandom_range(0, 99) < 3) b = spoil_digit(b);
      send_request($urandom_range(0, 1) ? CMD_SUB : CMD_ADD, a, 1'($urandom_range(0, 1)),
                   b, 1'($urandom_range(0, 1)));
    end
    quiet = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* signed_bcd_add_subtract_unit.f */
+incdir+rtl
rtl/sbcd_pkg.sv
rtl/sbcd_in_if.sv
rtl/sbcd_out_if.sv
rtl/sbcd_front.sv
rtl/sbcd_cell.sv
rtl/signed_bcd_add_subtract_unit.sv
tb/sbcd_result_checker.sv
tb/signed_bcd_add_subtract_unit_test.sv
